@@ rtl/core/pbm_pkg.sv @@
// Shared types and constants for the P1 bitmap set-pixel extractor.
// Item and result structs, result kinds, character codes, default sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pbm_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int MAG_BITS       = 17;
	localparam logic [MAG_BITS-1:0] MAG_MAX = 17'h1FFFF;
	localparam logic [1:0] TOPLINES = 2'd2;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_HASH  = 8'h23;

	typedef enum logic [1:0] {
		KIND_PIXEL  = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] row;
		logic [15:0] col;
		logic [15:0] width;
		logic [15:0] height;
	} out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/pbm_parse.sv @@
// Parse state and per-byte update for the P1 bitmap extractor.
// Holds word, line and pixel counters; emits at most one result per byte.
// Depends on pbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbm_parse #(
	parameter int COORD_BITS = pbm_pkg::COORD_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire pbm_pkg::in_item_t item,
	output logic                   res_valid,
	output pbm_pkg::out_item_t     res
);
	import pbm_pkg::*;

	localparam int VW = (COORD_BITS > MAG_BITS) ? COORD_BITS : MAG_BITS;

	logic                  in_word_q, negative_q, digits_ended_q, in_comment_q, halted_q;
	logic [MAG_BITS-1:0]   value_q;
	logic [1:0]            line_q, widx_q;
	logic [COORD_BITS-1:0] img_w_q, img_h_q, row_q, col_q;

	logic                  c_in_word, c_negative, c_digits_ended, c_in_comment, c_halted;
	logic [MAG_BITS-1:0]   c_value;
	logic [1:0]            c_line, c_widx;
	logic [COORD_BITS-1:0] c_img_w, c_img_h, c_row, c_col;

	logic                  n_in_word, n_negative, n_digits_ended, n_in_comment, n_halted;
	logic [MAG_BITS-1:0]   n_value;
	logic [1:0]            n_line, n_widx;
	logic [COORD_BITS-1:0] n_img_w, n_img_h, n_row, n_col;

	logic [7:0]            b;
	logic                  is_digit, is_sep, is_start, is_cont, one, err;
	logic [3:0]            dval;
	logic [MAG_BITS+3:0]   acc;
	logic [COORD_BITS-1:0] hv;
	logic [COORD_BITS:0]   col_inc;

	always_comb begin
		// file start clears everything ahead of its own byte
		c_in_word      = item.file_start ? 1'b0 : in_word_q;
		c_negative     = item.file_start ? 1'b0 : negative_q;
		c_digits_ended = item.file_start ? 1'b0 : digits_ended_q;
		c_in_comment   = item.file_start ? 1'b0 : in_comment_q;
		c_halted       = item.file_start ? 1'b0 : halted_q;
		c_value        = item.file_start ? '0 : value_q;
		c_line         = item.file_start ? '0 : line_q;
		c_widx         = item.file_start ? '0 : widx_q;
		c_img_w        = item.file_start ? '0 : img_w_q;
		c_img_h        = item.file_start ? '0 : img_h_q;
		c_row          = item.file_start ? '0 : row_q;
		c_col          = item.file_start ? '0 : col_q;

		b        = item.data_byte;
		is_digit = (b >= CH_0) && (b <= CH_9);
		is_sep   = (b == CH_SPACE) || (b == CH_NL) || (b == CH_HASH);
		is_start = (b == CH_P) || (b == CH_PLUS) || (b == CH_MINUS) || (b == CH_DOT) || is_digit;
		is_cont  = (b == CH_DOT) || (b == CH_P) || is_digit;
		dval     = 4'(b - CH_0);
		acc      = ({4'b0, c_value} << 3) + ({4'b0, c_value} << 1) + (MAG_BITS+4)'(dval);
		one      = !c_negative && (c_value == MAG_BITS'(1));
		if (c_negative)
			hv = '0;
		else if (VW'(c_value) > VW'({COORD_BITS{1'b1}}))
			hv = '1;
		else
			hv = COORD_BITS'(c_value);
		col_inc = {1'b0, c_col} + (COORD_BITS+1)'(1);

		n_in_word      = c_in_word;
		n_negative     = c_negative;
		n_digits_ended = c_digits_ended;
		n_in_comment   = c_in_comment;
		n_halted       = c_halted;
		n_value        = c_value;
		n_line         = c_line;
		n_widx         = c_widx;
		n_img_w        = c_img_w;
		n_img_h        = c_img_h;
		n_row          = c_row;
		n_col          = c_col;
		err            = 1'b0;
		res_valid      = 1'b0;
		res            = '0;
		res.kind       = KIND_PIXEL;

		if (!c_halted) begin
			if (c_in_comment) begin
				if (b == CH_NL)
					n_in_comment = 1'b0;
			end else if (is_sep) begin
				if (c_in_word) begin
					n_in_word = 1'b0;
					if (c_line == TOPLINES - 2'd1) begin
						if (c_widx == 2'd1) begin
							n_img_w = hv;
						end else if (c_widx == 2'd2) begin
							n_img_h    = hv;
							res_valid  = 1'b1;
							res.kind   = KIND_HEADER;
							res.width  = 16'(c_img_w);
							res.height = 16'(hv);
						end
					end else if (c_line >= TOPLINES && one) begin
						if (c_widx < 2'd3 || c_img_w == '0) begin
							err = 1'b1;
						end else begin
							res_valid = 1'b1;
							res.kind  = KIND_PIXEL;
							res.row   = 16'(c_row);
							res.col   = 16'(c_col);
						end
					end
					if (!err) begin
						if (c_widx >= 2'd3) begin
							if (col_inc >= {1'b0, c_img_w}) begin
								n_col = '0;
								if (c_row != '1)
									n_row = c_row + COORD_BITS'(1);
							end else begin
								n_col = col_inc[COORD_BITS-1:0];
							end
						end else begin
							n_widx = c_widx + 2'd1;
						end
					end
				end
				if (!err) begin
					if (b == CH_HASH)
						n_in_comment = 1'b1;
					else if (b == CH_NL && c_line < TOPLINES)
						n_line = c_line + 2'd1;
				end
			end else if (!c_in_word && is_start) begin
				n_in_word      = 1'b1;
				n_value        = is_digit ? MAG_BITS'(dval) : '0;
				n_negative     = (b == CH_MINUS);
				n_digits_ended = (b == CH_P) || (b == CH_DOT);
			end else if (c_in_word && is_cont) begin
				if (!is_digit)
					n_digits_ended = 1'b1;
				else if (!c_digits_ended)
					n_value = (acc > (MAG_BITS+4)'(MAG_MAX)) ? MAG_MAX : acc[MAG_BITS-1:0];
			end else begin
				err = 1'b1;
			end
			if (err) begin
				n_halted  = 1'b1;
				res_valid = 1'b1;
				res       = '0;
				res.kind  = KIND_ERROR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q      <= 1'b0;
			negative_q     <= 1'b0;
			digits_ended_q <= 1'b0;
			in_comment_q   <= 1'b0;
			halted_q       <= 1'b0;
			value_q        <= '0;
			line_q         <= '0;
			widx_q         <= '0;
			img_w_q        <= '0;
			img_h_q        <= '0;
			row_q          <= '0;
			col_q          <= '0;
		end else if (advance) begin
			in_word_q      <= n_in_word;
			negative_q     <= n_negative;
			digits_ended_q <= n_digits_ended;
			in_comment_q   <= n_in_comment;
			halted_q       <= n_halted;
			value_q        <= n_value;
			line_q         <= n_line;
			widx_q         <= n_widx;
			img_w_q        <= n_img_w;
			img_h_q        <= n_img_h;
			row_q          <= n_row;
			col_q          <= n_col;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pbm_ascii_set_pixel_extractor.sv @@
// Top level of the P1 bitmap set-pixel extractor: input register, parser, result register.
// Depends on pbm_pkg and pbm_parse.
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+----------------------------------
//   in       | item_valid    | item_stall    | item   (data_byte, file_start)
//   out      | result_valid  | result_stall  | result (kind, row, col, width, height)
//
// One byte per cycle while the result side is not stalled. A byte is captured in the
// input register, parsed against the parse state when it advances, and its result
// (if any) lands in the result register. The next parse state, including the
// multiply by ten of the word value, is computed combinationally.
// arst_n clears all parse state and both valid flags.
// A stalled result holds the input register; item_stall rises only then.
`timescale 1ns / 1ps
`default_nettype none

module pbm_ascii_set_pixel_extractor #(
	parameter int COORD_BITS = pbm_pkg::COORD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire pbm_pkg::in_item_t  item,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output pbm_pkg::out_item_t      result
);
	import pbm_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_q;
	logic      result_valid_q;

	logic      advance;
	logic      res_valid;
	out_item_t res;

	// advance the held byte whenever the result register is free or being drained
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// payload register: capture on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	pbm_parse #(
		.COORD_BITS(COORD_BITS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= res_valid;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

@@ tb/sv/pbm_result_scoreboard_pkg.sv @@
// Result tracker for the P1 bitmap set-pixel extractor bench: parses each accepted byte
// and compares every result against the oldest expected one.
// Depends on pbm_pkg.
`timescale 1ns / 1ps

package pbm_result_scoreboard_pkg;

	import pbm_pkg::*;

	class pbm_result_scoreboard;

		// Parse state, cleared at construction and by a file start.
		bit          in_word;
		bit          word_negative;
		bit          digits_stopped;
		bit          in_comment;
		bit          halted;
		logic [16:0] word_mag;
		logic [1:0]  line_no;
		logic [1:0]  word_no;
		logic [15:0] img_width;
		logic [15:0] img_height;
		logic [15:0] row_cnt;
		logic [15:0] col_cnt;

		out_item_t   pending_results[$];
		int unsigned error_count;

		function new();
			error_count = 0;
			clear_state();
		endfunction

		function void clear_state();
			in_word        = 1'b0;
			word_negative  = 1'b0;
			digits_stopped = 1'b0;
			in_comment     = 1'b0;
			halted         = 1'b0;
			word_mag       = '0;
			line_no        = '0;
			word_no        = '0;
			img_width      = '0;
			img_height     = '0;
			row_cnt        = '0;
			col_cnt        = '0;
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction

		function void post(kind_t k, logic [15:0] r, logic [15:0] c, logic [15:0] w,
				logic [15:0] h);
			pending_results.push_back(out_item_t'{kind: k, row: r, col: c, width: w, height: h});
		endfunction

		// Negative dimension words read as zero; large ones clip to the coordinate range.
		function logic [15:0] dim_value();
			if (word_negative)
				return 16'd0;
			return (word_mag > 17'h0FFFF) ? 16'hFFFF : word_mag[15:0];
		endfunction

		function void raise_error();
			halted = 1'b1;
			post(KIND_ERROR, '0, '0, '0, '0);
		endfunction

		function void close_word();
			bit is_one;
			is_one  = !word_negative && word_mag == 17'd1;
			in_word = 1'b0;
			if (line_no == TOPLINES - 2'd1) begin
				if (word_no == 2'd1) begin
					img_width = dim_value();
				end else if (word_no == 2'd2) begin
					img_height = dim_value();
					post(KIND_HEADER, '0, '0, img_width, img_height);
				end
			end else if (line_no >= TOPLINES && is_one) begin
				if (word_no != 2'd3 || img_width == 16'd0) begin
					raise_error();
					return;
				end
				post(KIND_PIXEL, row_cnt, col_cnt, '0, '0);
			end
			if (word_no == 2'd3) begin
				if ({1'b0, col_cnt} + 17'd1 >= {1'b0, img_width}) begin
					col_cnt = '0;
					if (row_cnt != 16'hFFFF)
						row_cnt++;
				end else begin
					col_cnt++;
				end
			end else begin
				word_no++;
			end
		endfunction

		function void note_byte(in_item_t it);
			logic [7:0]  c;
			bit          digit;
			logic [20:0] grown;
			c     = it.data_byte;
			digit = c >= CH_0 && c <= CH_9;
			if (it.file_start)
				clear_state();
			if (halted)
				return;
			if (in_comment) begin
				if (c == CH_NL)
					in_comment = 1'b0;
				return;
			end
			if (c == CH_SPACE || c == CH_NL || c == CH_HASH) begin
				if (in_word)
					close_word();
				if (halted)
					return;
				if (c == CH_HASH)
					in_comment = 1'b1;
				else if (c == CH_NL && line_no < TOPLINES)
					line_no++;
				return;
			end
			if (!in_word && (c == CH_P || c == CH_PLUS || c == CH_MINUS || c == CH_DOT || digit)) begin
				in_word        = 1'b1;
				word_mag       = digit ? 17'(c - CH_0) : 17'd0;
				word_negative  = c == CH_MINUS;
				digits_stopped = c == CH_P || c == CH_DOT;
				return;
			end
			if (in_word && (c == CH_DOT || c == CH_P || digit)) begin
				if (!digit) begin
					digits_stopped = 1'b1;
				end else if (!digits_stopped) begin
					grown    = {4'd0, word_mag} * 21'd10 + 21'(c - CH_0);
					word_mag = (grown > {4'd0, MAG_MAX}) ? MAG_MAX : grown[16:0];
				end
				return;
			end
			raise_error();
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
				error_count++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing pending, kind %0d row %0d col %0d w %0d h %0d",
					$time, got.kind, got.row, got.col, got.width, got.height);
				error_count++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("kind", 16'(want.kind), 16'(got.kind));
			compare_field("row", want.row, got.row);
			compare_field("col", want.col, got.col);
			compare_field("width", want.width, got.width);
			compare_field("height", want.height, got.height);
		endfunction

	endclass

endpackage

@@ tb/sv/tb_pbm_ascii_set_pixel_extractor.sv @@
// Bench top for the P1 bitmap set-pixel extractor: builds a byte stream of bitmap files,
// drives it in bursts, stalls the result side and checks every result.
// Depends on pbm_pkg, pbm_result_scoreboard_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_pbm_ascii_set_pixel_extractor;

	import pbm_pkg::*;
	import pbm_result_scoreboard_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1400;
	// Nothing accepted on either side for this many cycles means the block hung.
	localparam int unsigned IDLE_LIMIT   = 4000;
	// Margin after the last pending result, for a late extra result.
	localparam int unsigned DRAIN_CYCLES = 8;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	in_item_t  item         = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	pbm_result_scoreboard pixel_sb;

	in_item_t    text_q[$];   // whole byte stream, built before reset is released
	int unsigned pause_q[$];  // stream positions where the sender waits for all results
	int unsigned idle_cycles = 0;

	// Receiver stall pattern state.
	int unsigned stall_mode = 0;
	int unsigned mode_left  = 0;
	int unsigned cycle_cnt  = 0;

	pbm_ascii_set_pixel_extractor u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Stream building
	// ------------------------------------------------------------------

	task automatic put_ch(input logic [7:0] c, input bit fs = 1'b0);
		text_q.push_back(in_item_t'{data_byte: c, file_start: fs});
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put_ch(s[i]);
	endtask

	// Comment body may hold any byte except newline, which ends it.
	task automatic put_comment();
		logic [7:0] c;
		put_ch(CH_HASH);
		repeat ($urandom_range(0, 5)) begin
			c = 8'($urandom_range(0, 255));
			put_ch((c == CH_NL) ? CH_SPACE : c);
		end
		put_ch(CH_NL);
	endtask

	task automatic put_sep();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7)
			put_ch(CH_SPACE);
		else if (r < 9)
			put_ch(CH_NL);
		else
			put_str(" \n ");
	endtask

	// Plain 0/1 cells in 7 of 17 picks; the rest exercise signs, dots, P and long digit runs.
	task automatic put_pixel_word();
		case ($urandom_range(0, 16))
			0, 1, 2, 3, 4, 5, 6: put_ch(CH_0 + 8'($urandom_range(0, 1)));
			7:  put_str("+1");
			8:  put_str("-1");
			9:  put_str("001");
			10: put_str("1.9");
			11: put_str("1P");
			12: put_str("P1");
			13: put_str(".");
			14: put_str("-");
			15: put_str("+");
			default: put_str($sformatf("%0d", $urandom_range(0, 9999999)));
		endcase
	endtask

	function automatic string dim_text();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $sformatf("%0d", $urandom_range(1, 8));
		if (r == 14)
			return "0";
		if (r == 15)
			return $sformatf("%0d", $urandom_range(9, 40));
		if (r == 16)
			return "-4";
		if (r == 17)
			return "65535";
		if (r == 18)
			return "65536";
		return $sformatf("%0d", $urandom_range(70000, 9999999));
	endfunction

	// One bitmap file; a corrupted one gets one byte overwritten with a random value.
	task automatic put_file(input bit corrupt);
		int unsigned first;
		int unsigned n_words;
		int unsigned pos;
		first = text_q.size();
		if ($urandom_range(0, 7) == 0)
			put_comment();
		if ($urandom_range(0, 9) == 0) begin
			// skip the header: the first one-valued cell comes before three words and is an error
			put_str("\n\n");
		end else begin
			put_str("P1");
			put_ch(CH_NL);
			if ($urandom_range(0, 5) == 0)
				put_comment();
			put_str(dim_text());
			put_ch(CH_SPACE);
			put_str(dim_text());
			if ($urandom_range(0, 5) == 0) begin
				put_ch(CH_SPACE);
				put_pixel_word();
			end
			if ($urandom_range(0, 5) == 0)
				put_comment();
			put_ch(CH_NL);
		end
		n_words = $urandom_range(1, 40);
		for (int unsigned k = 0; k < n_words; k++) begin
			put_pixel_word();
			if ($urandom_range(0, 19) == 0)
				put_comment();
			else if (k + 1 < n_words || $urandom_range(0, 4) != 0)
				put_sep();
		end
		if (corrupt) begin
			pos = $urandom_range(first, text_q.size() - 1);
			text_q[pos].data_byte = 8'($urandom_range(0, 255));
		end
		text_q[first].file_start = 1'b1;
	endtask

	task automatic put_noise();
		repeat ($urandom_range(1, 12))
			put_ch(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
	endtask

	task automatic build_stream();
		int unsigned stop_at;
		// Zero width from a negative word, then a one-cell trips the zero-width error;
		// the all-ones byte that follows is ignored while halted.
		put_ch(CH_P, 1'b1);
		put_str("\n-3 2\n1 ");
		put_ch(8'hFF);
		// A one-cell on line 2 before three words have been seen.
		put_ch(CH_NL, 1'b1);
		put_str("\n1 ");
		// Clipped width, a comment closing the height word, one pixel, then a word
		// left open when the next file starts.
		put_ch(CH_P, 1'b1);
		put_str("\n70000 1#\n\n1 1");
		// Illegal character at the very start of a file.
		put_ch(8'h00, 1'b1);
		pause_q.push_back(text_q.size());

		stop_at = text_q.size() + RANDOM_ITEMS;
		while (text_q.size() < stop_at) begin
			case ($urandom_range(0, 9))
				7, 8:    put_file(1'b1);
				9:       put_noise();
				default: put_file(1'b0);
			endcase
			if ($urandom_range(0, 11) == 0)
				pause_q.push_back(text_q.size());
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: note accepted bytes, check accepted results, drive the stall pattern
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				pixel_sb.note_byte(item);
			if (result_valid && !result_stall)
				pixel_sb.check_result(result);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
		// Switch stall pattern now and then: none, light, heavy, periodic.
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(20, 300);
		end else begin
			mode_left--;
		end
		cycle_cnt++;
		case (stall_mode)
			0:       result_stall <= 1'b0;
			1:       result_stall <= $urandom_range(0, 3) == 0;
			2:       result_stall <= $urandom_range(0, 9) < 7;
			default: result_stall <= (cycle_cnt % 7) < 3;
		endcase
	end

	// Watchdog: end the run if the block stops moving.
	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------

	initial begin
		int unsigned burst_left;
		pixel_sb   = new();
		burst_left = 0;
		build_stream();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned i = 0; i < text_q.size(); i++) begin
			// Hold off until every expected result has drained.
			if (pause_q.size() != 0 && pause_q[0] == i) begin
				void'(pause_q.pop_front());
				item_valid <= 1'b0;
				@(posedge clk);
				while (pixel_sb.pending() != 0)
					@(posedge clk);
			end
			// Burst over: drop valid for a short gap, then start a new burst.
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 500)
				                                         : $urandom_range(1, 30);
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			item       <= text_q[i];
			item_valid <= 1'b1;
			@(posedge clk);
			while (item_stall)
				@(posedge clk);
			burst_left--;
		end
		item_valid <= 1'b0;

		// Drain: wait for the last results, then DRAIN_CYCLES more for anything extra.
		@(posedge clk);
		while (pixel_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pixel_sb.error_count == 0 && pixel_sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
